FILE: sv/ffbp_pkg.sv
// ----------------------------------------------------------------------------
// ffbp_pkg
// Shared types and constants for the fixed block pool free-list allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffbp_pkg;

  localparam int unsigned POOL_SIZE = 32;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned CNT_W     = 6;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef struct packed {
    logic load_req;
    logic rd_link;
    logic commit;
  } ctl_cmd_t;

endpackage

`default_nettype wire

FILE: sv/fifo_free_list_block_pool_unit.sv
// ----------------------------------------------------------------------------
// fifo_free_list_block_pool_unit
// Fixed block pool allocator with a FIFO-ordered linked free list.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive kind_i (0 allocate, 1 release) and release_index_i
//   and raise start; the item is taken at a rising edge with start high and
//   busy low. busy stays high while the item is read and committed.
//   Result channel: result_valid_o pulses for one cycle with granted_o,
//   granted_index_o, status_o and blocks_free_o; the receiver cannot stall
//   and must take the item in that cycle.
//   Result timing: the result is registered after the sequencer's commit state.
//   Sequencing: no new item is taken while busy, since the sequencer reads the
//   link store at the head (registered read) before committing the update.
//   A new item may be accepted in the same cycle the previous result shows.
//   Reset: the free list holds blocks 0 to POOL_SIZE-1 in order, all free;
//   link entries read their reset value until first written, so no clearing
//   pass is needed and the block is ready right after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fifo_free_list_block_pool_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        kind_i,
  input  wire logic [ffbp_pkg::IDX_W-1:0]  release_index_i,
  output logic                             result_valid_o,
  output logic                             granted_o,
  output logic [ffbp_pkg::IDX_W-1:0]       granted_index_o,
  output logic [1:0]                       status_o,
  output logic [ffbp_pkg::CNT_W-1:0]       blocks_free_o
);
  import ffbp_pkg::*;

  ctl_cmd_t cmd;

  ffbp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  ffbp_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .kind_i          (kind_i),
    .release_index_i (release_index_i),
    .result_valid_o  (result_valid_o),
    .granted_o       (granted_o),
    .granted_index_o (granted_index_o),
    .status_o        (status_o),
    .blocks_free_o   (blocks_free_o)
  );

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && granted_o) |-> (status_o == ST_OK))
    else $error("grant with error status");

  a_nogrant_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !granted_o) |-> (granted_index_o == '0))
    else $error("index without grant");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blocks_free_o <= CNT_W'(POOL_SIZE))
    else $error("free count above pool size");

  a_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 result_valid_o)
    else $error("missing result after accepted item");

endmodule

`default_nettype wire

FILE: sv/ffbp_ctrl.sv
// ----------------------------------------------------------------------------
// ffbp_ctrl
// Sequencer: capture item, read link store at head, commit list update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffbp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  output ffbp_pkg::ctl_cmd_t     cmd_o
);
  import ffbp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_link = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        cmd_o.commit = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ffbp_datapath.sv
// ----------------------------------------------------------------------------
// ffbp_datapath
// Head, tail, free count, link store and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffbp_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ffbp_pkg::ctl_cmd_t          cmd_i,
  input  wire logic                        kind_i,
  input  wire logic [ffbp_pkg::IDX_W-1:0]  release_index_i,
  output logic                             result_valid_o,
  output logic                             granted_o,
  output logic [ffbp_pkg::IDX_W-1:0]       granted_index_o,
  output logic [1:0]                       status_o,
  output logic [ffbp_pkg::CNT_W-1:0]       blocks_free_o
);
  import ffbp_pkg::*;

  logic             kind_q;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [IDX_W-1:0] link_mem [POOL_SIZE];
  logic [POOL_SIZE-1:0] link_vld_q;
  logic [IDX_W-1:0] link_rd_q;
  logic             link_rd_vld_q;
  logic [IDX_W-1:0] link_dflt;
  logic [IDX_W-1:0] link_next;

  logic             wr_en;
  logic             res_granted;
  logic [IDX_W-1:0] res_index;
  status_e          res_status;

  logic             valid_q;
  logic             granted_q;
  logic [IDX_W-1:0] gidx_q;
  status_e          status_q;

  // unwritten entries hold their reset link: next block, wrapping at the end
  assign link_dflt = (head_q == IDX_W'(POOL_SIZE - 1)) ? '0 : head_q + IDX_W'(1);
  assign link_next = link_rd_vld_q ? link_rd_q : link_dflt;

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    wr_en       = 1'b0;
    res_granted = 1'b0;
    res_index   = '0;
    res_status  = ST_OK;
    if (kind_q == KIND_ALLOC) begin
      if (cnt_q == '0) begin
        res_status = ST_EMPTY;
      end else begin
        res_granted = 1'b1;
        res_index   = head_q;
        head_d      = link_next;
        cnt_d       = cnt_q - CNT_W'(1);
      end
    end else begin
      if (CNT_W'(idx_q) >= CNT_W'(POOL_SIZE)) begin
        res_status = ST_RANGE;
      end else if (cnt_q >= CNT_W'(POOL_SIZE)) begin
        res_status = ST_FULL;
      end else begin
        if (cnt_q == '0) begin
          head_d = idx_q;
        end else begin
          wr_en = 1'b1;
        end
        tail_d = idx_q;
        cnt_d  = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      kind_q <= kind_i;
      idx_q  <= release_index_i;
    end
    if (cmd_i.rd_link) begin
      link_rd_q     <= link_mem[head_q];
      link_rd_vld_q <= link_vld_q[head_q];
    end
    if (cmd_i.commit && wr_en) begin
      link_mem[tail_q] <= idx_q;
    end
    if (cmd_i.commit) begin
      granted_q <= res_granted;
      gidx_q    <= res_index;
      status_q  <= res_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= IDX_W'(POOL_SIZE - 1);
      cnt_q      <= CNT_W'(POOL_SIZE);
      link_vld_q <= '0;
      valid_q    <= 1'b0;
    end else begin
      valid_q <= cmd_i.commit;
      if (cmd_i.commit) begin
        head_q <= head_d;
        tail_q <= tail_d;
        cnt_q  <= cnt_d;
        if (wr_en) begin
          link_vld_q[tail_q] <= 1'b1;
        end
      end
    end
  end

  assign result_valid_o  = valid_q;
  assign granted_o       = granted_q;
  assign granted_index_o = gidx_q;
  assign status_o        = status_q;
  assign blocks_free_o   = cnt_q;

endmodule

`default_nettype wire
